[hw/rtl/vhpd_pkg.sv]
`default_nettype none
package vhpd_pkg;

  localparam int TABLE_SLOTS  = 8192;
  localparam int MAX_VERTICES = 4096;
  localparam int COORD_BITS   = 24;
  localparam int SLOT_BITS    = $clog2(TABLE_SLOTS);
  localparam int VTX_BITS     = $clog2(MAX_VERTICES);
  localparam int VSIZE_BITS   = 16;
  localparam logic [31:0] HASH_GOLD = 32'h9e37_79b9;
  localparam logic [VSIZE_BITS-1:0] VSIZE_RESET = 16'd50;

  typedef enum logic [2:0] {
    ST_EXISTING = 3'd0,
    ST_NEW      = 3'd1,
    ST_SKIPPED  = 3'd2,
    ST_FULL     = 3'd3,
    ST_TICK     = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_SKIP  = 2'd1,
    CMD_POINT = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t             kind;
    logic [COORD_BITS-1:0] kx;
    logic [COORD_BITS-1:0] ky;
    logic [COORD_BITS-1:0] kz;
    logic [SLOT_BITS-1:0]  home;
  } cmd_t;

  typedef struct packed {
    logic                  used;
    logic [COORD_BITS-1:0] kx;
    logic [COORD_BITS-1:0] ky;
    logic [COORD_BITS-1:0] kz;
    logic [VTX_BITS-1:0]   vertex;
  } slot_t;

  typedef struct packed {
    status_t             status;
    logic [VTX_BITS-1:0] vertex_index;
    logic [31:0]         observation_count;
    logic [31:0]         keyframe_number;
  } result_t;

  function automatic logic [31:0] hash_mix(input logic [31:0] h, input logic [31:0] k);
    hash_mix = h ^ (k + HASH_GOLD + (h << 6) + (h >> 2));
  endfunction

endpackage
`default_nettype wire

[hw/rtl/vhpd_front.sv]
`default_nettype none
module vhpd_front import vhpd_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  hold,
  input  wire logic [VSIZE_BITS-1:0] vox_edge,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  in_opcode,
  input  wire logic                  in_point_valid,
  input  wire logic [COORD_BITS-1:0] in_x,
  input  wire logic [COORD_BITS-1:0] in_y,
  input  wire logic [COORD_BITS-1:0] in_z,
  output logic                       cmd_valid,
  input  wire logic                  cmd_ready,
  output cmd_t                       cmd
);

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_DIV  = 4'b0010,
    F_HASH = 4'b0100,
    F_PUSH = 4'b1000
  } fstate_t;

  localparam int STEP_BITS = $clog2(COORD_BITS);

  fstate_t state;
  logic [STEP_BITS-1:0] step;
  logic [1:0] hstep;
  logic [VSIZE_BITS-1:0] divisor;
  logic [COORD_BITS-1:0] quo [3];
  logic [VSIZE_BITS-1:0] rem [3];
  logic neg [3];
  logic [31:0] h;
  cmd_kind_t kind;
  logic [COORD_BITS-1:0] key [3];
  logic [COORD_BITS-1:0] coord [3];
  logic [VSIZE_BITS:0] rem_sh [3];
  logic [31:0] k_sel;

  assign coord[0] = in_x;
  assign coord[1] = in_y;
  assign coord[2] = in_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rem_sh[i] = {rem[i], quo[i][COORD_BITS-1]};
      if (neg[i]) begin
        key[i] = (rem[i] != '0) ? ~quo[i] : (~quo[i] + 1'b1);
      end else begin
        key[i] = quo[i];
      end
    end
    unique case (hstep)
      2'd0:    k_sel = {{(32-COORD_BITS){key[0][COORD_BITS-1]}}, key[0]};
      2'd1:    k_sel = {{(32-COORD_BITS){key[1][COORD_BITS-1]}}, key[1]};
      default: k_sel = {{(32-COORD_BITS){key[2][COORD_BITS-1]}}, key[2]};
    endcase
  end

  assign in_ready  = (state == F_IDLE) && !hold;
  assign cmd_valid = (state == F_PUSH);
  assign cmd.kind  = kind;
  assign cmd.kx    = key[0];
  assign cmd.ky    = key[1];
  assign cmd.kz    = key[2];
  assign cmd.home  = h[SLOT_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (in_valid && in_ready) begin
            step    <= '0;
            hstep   <= '0;
            h       <= '0;
            divisor <= (vox_edge == '0) ? VSIZE_BITS'(1) : vox_edge;
            for (int i = 0; i < 3; i++) begin
              neg[i] <= coord[i][COORD_BITS-1];
              quo[i] <= coord[i][COORD_BITS-1] ? (~coord[i] + 1'b1) : coord[i];
              rem[i] <= '0;
            end
            if (!in_opcode) begin
              kind  <= CMD_TICK;
              state <= F_PUSH;
            end else if (!in_point_valid || (in_x == '0 && in_y == '0 && in_z == '0)) begin
              kind  <= CMD_SKIP;
              state <= F_PUSH;
            end else begin
              kind  <= CMD_POINT;
              state <= F_DIV;
            end
          end
        end
        F_DIV: begin
          for (int i = 0; i < 3; i++) begin
            if (rem_sh[i] >= {1'b0, divisor}) begin
              rem[i] <= VSIZE_BITS'(rem_sh[i] - {1'b0, divisor});
              quo[i] <= {quo[i][COORD_BITS-2:0], 1'b1};
            end else begin
              rem[i] <= rem_sh[i][VSIZE_BITS-1:0];
              quo[i] <= {quo[i][COORD_BITS-2:0], 1'b0};
            end
          end
          step <= step + 1'b1;
          if (step == STEP_BITS'(COORD_BITS - 1)) begin
            state <= F_HASH;
          end
        end
        F_HASH: begin
          h     <= hash_mix(h, k_sel);
          hstep <= hstep + 1'b1;
          if (hstep == 2'd2) begin
            state <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (cmd_ready) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[hw/rtl/vhpd_fifo.sv]
`default_nettype none
module vhpd_fifo import vhpd_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr_valid,
  output logic      wr_ready,
  input  cmd_t      wr_data,
  output logic      rd_valid,
  input  wire logic rd_ready,
  output cmd_t      rd_data
);

  cmd_t store [2];
  logic wptr;
  logic rptr;
  logic [1:0] fill;
  logic do_wr;
  logic do_rd;

  assign wr_ready = (fill != 2'd2);
  assign rd_valid = (fill != 2'd0);
  assign rd_data  = store[rptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      store[wptr] <= wr_data;
    end
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (do_wr) wptr <= ~wptr;
      if (do_rd) rptr <= ~rptr;
      fill <= fill + 2'(do_wr) - 2'(do_rd);
    end
  end

endmodule
`default_nettype wire

[hw/rtl/vhpd_back.sv]
`default_nettype none
module vhpd_back import vhpd_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  output logic      clearing,
  input  wire logic cmd_valid,
  output logic      cmd_ready,
  input  cmd_t      cmd,
  output logic      res_valid,
  input  wire logic res_ready,
  output result_t   res
);

  typedef enum logic [5:0] {
    B_CLR  = 6'b000001,
    B_IDLE = 6'b000010,
    B_RD   = 6'b000100,
    B_CMP  = 6'b001000,
    B_CRD  = 6'b010000,
    B_CUPD = 6'b100000
  } bstate_t;

  bstate_t state;
  slot_t tbl [TABLE_SLOTS];
  logic [31:0] cnt_mem [MAX_VERTICES];
  slot_t tbl_rdata;
  logic [31:0] cnt_rdata;
  logic [SLOT_BITS-1:0] slot;
  logic [SLOT_BITS-1:0] probes;
  logic [VTX_BITS-1:0] vreg;
  logic [VTX_BITS:0] next_vertex;
  logic [31:0] frame_counter;
  cmd_t cur;
  logic tbl_we;
  logic [SLOT_BITS-1:0] tbl_waddr;
  slot_t tbl_wdata;
  logic cnt_we;
  logic [31:0] cnt_wdata;
  logic hit;
  logic [31:0] cnt_inc;

  assign clearing  = (state == B_CLR);
  assign cmd_ready = (state == B_IDLE) && !res_valid;
  assign hit = tbl_rdata.used && tbl_rdata.kx == cur.kx && tbl_rdata.ky == cur.ky
               && tbl_rdata.kz == cur.kz;
  assign cnt_inc = (cnt_rdata == 32'hFFFF_FFFF) ? cnt_rdata : cnt_rdata + 1'b1;

  always_comb begin
    tbl_we    = 1'b0;
    tbl_waddr = slot;
    tbl_wdata = '{used: 1'b1, kx: cur.kx, ky: cur.ky, kz: cur.kz,
                  vertex: next_vertex[VTX_BITS-1:0]};
    cnt_we    = 1'b0;
    cnt_wdata = 32'd1;
    if (state == B_CLR) begin
      tbl_we    = 1'b1;
      tbl_waddr = probes;
      tbl_wdata = '0;
    end else if (state == B_CMP && !tbl_rdata.used && !next_vertex[VTX_BITS]) begin
      tbl_we = 1'b1;
      cnt_we = 1'b1;
    end else if (state == B_CUPD) begin
      cnt_we    = 1'b1;
      cnt_wdata = cnt_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (tbl_we) tbl[tbl_waddr] <= tbl_wdata;
    tbl_rdata <= tbl[slot];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_we && state == B_CMP ? next_vertex[VTX_BITS-1:0] : vreg]
      <= cnt_wdata;
    cnt_rdata <= cnt_mem[vreg];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= B_CLR;
      probes        <= '0;
      next_vertex   <= '0;
      frame_counter <= '0;
      res_valid     <= 1'b0;
    end else begin
      if (res_valid && res_ready) res_valid <= 1'b0;
      unique case (state)
        B_CLR: begin
          probes <= probes + 1'b1;
          if (probes == SLOT_BITS'(TABLE_SLOTS - 1)) state <= B_IDLE;
        end
        B_IDLE: begin
          if (cmd_valid && cmd_ready) begin
            cur                     <= cmd;
            slot                    <= cmd.home;
            probes                  <= '0;
            res.vertex_index        <= '0;
            res.observation_count   <= '0;
            unique case (cmd.kind)
              CMD_TICK: begin
                frame_counter       <= frame_counter + 1'b1;
                res.keyframe_number <= frame_counter + 1'b1;
                res.status          <= ST_TICK;
                res_valid           <= 1'b1;
              end
              CMD_SKIP: begin
                res.keyframe_number <= frame_counter;
                res.status          <= ST_SKIPPED;
                res_valid           <= 1'b1;
              end
              default: begin
                res.keyframe_number <= frame_counter;
                state               <= B_RD;
              end
            endcase
          end
        end
        B_RD: state <= B_CMP;
        B_CMP: begin
          if (!tbl_rdata.used) begin
            if (!next_vertex[VTX_BITS]) begin
              res.status            <= ST_NEW;
              res.vertex_index      <= next_vertex[VTX_BITS-1:0];
              res.observation_count <= 32'd1;
              next_vertex           <= next_vertex + 1'b1;
            end else begin
              res.status <= ST_FULL;
            end
            res_valid <= 1'b1;
            state     <= B_IDLE;
          end else if (hit) begin
            vreg  <= tbl_rdata.vertex;
            state <= B_CRD;
          end else if (probes == SLOT_BITS'(TABLE_SLOTS - 1)) begin
            res.status <= ST_FULL;
            res_valid  <= 1'b1;
            state      <= B_IDLE;
          end else begin
            probes <= probes + 1'b1;
            slot   <= slot + 1'b1;
            state  <= B_RD;
          end
        end
        B_CRD: state <= B_CUPD;
        B_CUPD: begin
          res.status            <= ST_EXISTING;
          res.vertex_index      <= vreg;
          res.observation_count <= cnt_inc;
          res_valid             <= 1'b1;
          state                 <= B_IDLE;
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[hw/rtl/voxel_hash_point_dedup_core.sv]
// channel   dir  tdata (low bit up)                        tuser (low bit up)
// s_axis    in   point_x[23:0] point_y[47:24] point_z[71:48]  opcode[0] point_valid[1]
// m_axis    out  vertex_index[11:0] observation_count[43:12]  status[2:0]
//                keyframe_number[75:44], zero pad [79:76]
// cfg       in   cfg_wr_en / cfg_wr_data = voxel edge in mm
// Tick or skipped point: no division or hashing; the result passes through the queue and the back.
// Point: restoring division (three lanes), hashing of the three keys, the queue, the
// start of the back, then a read and a compare per probe of the slot memory, plus a
// count read and update on a hit.
// After reset all 8192 slots of the table are cleared; s_axis_tready is low then.
// The front accepts the next item while the back probes; a held result stalls the back.
`default_nettype none
module voxel_hash_point_dedup_core import vhpd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [71:0] s_axis_tdata,  // point_x, point_y, point_z
  input  wire logic [1:0]  s_axis_tuser,  // opcode, point_valid
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [79:0]      m_axis_tdata,  // vertex_index, observation_count, keyframe_number
  output logic [2:0]       m_axis_tuser   // status
);

  logic [VSIZE_BITS-1:0] vox_edge;
  logic clearing;
  logic f_valid, f_ready, q_valid, q_ready;
  cmd_t f_cmd, q_cmd;
  result_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      vox_edge <= VSIZE_RESET;
    end else if (cfg_wr_en) begin
      vox_edge <= cfg_wr_data;
    end
  end

  vhpd_front u_front (
    .clk, .rst,
    .hold           (clearing),
    .vox_edge       (vox_edge),
    .in_valid       (s_axis_tvalid),
    .in_ready       (s_axis_tready),
    .in_opcode      (s_axis_tuser[0]),
    .in_point_valid (s_axis_tuser[1]),
    .in_x           (s_axis_tdata[23:0]),
    .in_y           (s_axis_tdata[47:24]),
    .in_z           (s_axis_tdata[71:48]),
    .cmd_valid      (f_valid),
    .cmd_ready      (f_ready),
    .cmd            (f_cmd)
  );

  vhpd_fifo u_fifo (
    .clk, .rst,
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (f_cmd),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_cmd)
  );

  vhpd_back u_back (
    .clk, .rst,
    .clearing  (clearing),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd       (q_cmd),
    .res_valid (m_axis_tvalid),
    .res_ready (m_axis_tready),
    .res       (res)
  );

  assign m_axis_tuser = res.status;
  assign m_axis_tdata = {4'b0, res.keyframe_number, res.observation_count, res.vertex_index};

endmodule
`default_nettype wire

[hw/rtl/vhpd_checker.sv]
`default_nettype none
module vhpd_checker import vhpd_pkg::*; (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [79:0] m_axis_tdata,
  input wire logic [2:0]  m_axis_tuser
);

  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_axis_tvalid && !s_axis_tready)
    else $error("activity right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  a_none: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == ST_SKIPPED || m_axis_tuser == ST_FULL
      || m_axis_tuser == ST_TICK) |-> m_axis_tdata[43:0] == '0)
    else $error("vertex or count on a result without a vertex");

  a_new_one: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == ST_NEW |-> m_axis_tdata[43:12] == 32'd1)
    else $error("new vertex count is not one");

  a_hit_count: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == ST_EXISTING |-> m_axis_tdata[43:12] >= 32'd2)
    else $error("existing vertex count below two");

endmodule

bind voxel_hash_point_dedup_core vhpd_checker u_vhpd_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire

[tb/sv/voxel_hash_point_dedup_core_tb.sv]
`default_nettype none
module voxel_hash_point_dedup_core_tb import vhpd_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  class dedup_scoreboard;
    bit             used [TABLE_SLOTS];
    bit [23:0]      sk_x [TABLE_SLOTS];
    bit [23:0]      sk_y [TABLE_SLOTS];
    bit [23:0]      sk_z [TABLE_SLOTS];
    bit [11:0]      s_vtx [TABLE_SLOTS];
    bit [31:0]      obs [MAX_VERTICES];
    bit [31:0]      last_frame [MAX_VERTICES];
    int unsigned    next_vtx;
    bit [31:0]      frames;
    bit [15:0]      vsize;
    result_t        pending [$];
    int             errors;

    function new();
      next_vtx = 0;
      frames = 0;
      vsize = VSIZE_RESET;
      errors = 0;
    endfunction

    function bit [31:0] fdiv(bit [23:0] raw, bit [15:0] d);
      longint p, q, dd;
      p = longint'($signed(raw));
      dd = (d == 0) ? 1 : longint'(d);
      q = p / dd;
      if ((p % dd) != 0 && p < 0) q = q - 1;
      return q[31:0];
    endfunction

    function bit [31:0] mixw(bit [31:0] h, bit [31:0] k);
      return h ^ (k + 32'h9e3779b9 + (h << 6) + (h >> 2));
    endfunction

    function void note_beat(bit op, bit pv, bit [23:0] px, bit [23:0] py, bit [23:0] pz);
      result_t r;
      bit [31:0] kx, ky, kz, h;
      int unsigned s, n, v;
      bit hit, empty;
      r = '0;
      if (!op) begin
        frames = frames + 1;
        r.status = ST_TICK;
      end else if (!pv || (px == 0 && py == 0 && pz == 0)) begin
        r.status = ST_SKIPPED;
      end else begin
        kx = fdiv(px, vsize);
        ky = fdiv(py, vsize);
        kz = fdiv(pz, vsize);
        h = mixw(mixw(mixw(0, kx), ky), kz);
        s = h % TABLE_SLOTS;
        hit = 0;
        empty = 0;
        for (n = 0; n < TABLE_SLOTS; n++) begin
          if (!used[s]) begin
            empty = 1;
            break;
          end
          if (sk_x[s] == kx[23:0] && sk_y[s] == ky[23:0] && sk_z[s] == kz[23:0]) begin
            hit = 1;
            break;
          end
          s = (s + 1) % TABLE_SLOTS;
        end
        if (hit) begin
          v = s_vtx[s];
          if (obs[v] != 32'hffffffff) obs[v] = obs[v] + 1;
          last_frame[v] = frames;
          r.status = ST_EXISTING;
          r.vertex_index = 12'(v);
          r.observation_count = obs[v];
        end else if (empty && next_vtx < MAX_VERTICES) begin
          v = next_vtx;
          used[s] = 1;
          sk_x[s] = kx[23:0];
          sk_y[s] = ky[23:0];
          sk_z[s] = kz[23:0];
          s_vtx[s] = 12'(v);
          obs[v] = 32'd1;
          last_frame[v] = frames;
          next_vtx = v + 1;
          r.status = ST_NEW;
          r.vertex_index = 12'(v);
          r.observation_count = 32'd1;
        end else begin
          r.status = ST_FULL;
        end
      end
      r.keyframe_number = frames;
      pending = {pending, r};
    endfunction

    function void check_beat(bit [2:0] st, bit [79:0] d);
      result_t e;
      if (pending.size() == 0) begin
        $error("unexpected result beat status=%0d", st);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (st != e.status) begin
        $error("status expected %0d actual %0d", e.status, st);
        errors++;
      end
      if (d[11:0] != e.vertex_index) begin
        $error("vertex_index expected %0d actual %0d", e.vertex_index, d[11:0]);
        errors++;
      end
      if (d[43:12] != e.observation_count) begin
        $error("observation_count expected %0d actual %0d", e.observation_count, d[43:12]);
        errors++;
      end
      if (d[75:44] != e.keyframe_number) begin
        $error("keyframe_number expected %0d actual %0d", e.keyframe_number, d[75:44]);
        errors++;
      end
      if (d[79:76] != 0) begin
        $error("pad expected 0 actual %0h", d[79:76]);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_wr_en = 0;
  logic [15:0] cfg_wr_data = '0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [79:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;

  dedup_scoreboard sb = new();
  int  idle_pct = 19;
  bit  hold_off = 0;
  int  quiet = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  voxel_hash_point_dedup_core u_top (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready)
      sb.note_beat(s_axis_tuser[0], s_axis_tuser[1], s_axis_tdata[23:0],
                   s_axis_tdata[47:24], s_axis_tdata[71:48]);
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_beat(m_axis_tuser, m_axis_tdata);
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet > 40000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (hold_off || rst)
      m_axis_tready <= 0;
    else
      m_axis_tready <= ($urandom_range(99) >= idle_pct);
  end

  task automatic send_beat(bit op, bit pv, bit [23:0] x, bit [23:0] y, bit [23:0] z);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser <= {pv, op};
    s_axis_tdata <= {z, y, x};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic write_size(bit [15:0] v);
    drain();
    cfg_wr_en <= 1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 0;
    sb.vsize = v;
  endtask

  function automatic bit [23:0] near_coord();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 24'($urandom());
    return 24'($signed($urandom_range(2000)) - 1000);
  endfunction

  task automatic random_beats(int count);
    int i;
    bit [23:0] x, y, z;
    for (i = 0; i < count; i++) begin
      case ($urandom_range(19))
        0: send_beat(1'b0, 1'($urandom), 24'($urandom), 24'($urandom), 24'($urandom));
        1: send_beat(1'b1, 1'b0, 24'($urandom), 24'($urandom), 24'($urandom));
        2: send_beat(1, 1, 0, 0, 0);
        default: begin
          x = near_coord();
          y = near_coord();
          z = near_coord();
          send_beat(1, 1, x, y, z);
        end
      endcase
    end
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst <= 0;
    send_beat(0, 0, 0, 0, 0);
    send_beat(1, 1, 0, 0, 0);
    send_beat(1, 0, 24'd100, 24'd5, 24'd7);
    send_beat(1, 1, 24'd100, 24'd5, 24'd7);
    send_beat(1, 1, 24'd120, 24'd30, 24'd40);
    send_beat(1, 1, -24'sd1, 24'd0, 24'd0);
    send_beat(1, 1, -24'sd50, 24'd0, 24'd0);
    send_beat(1, 1, -24'sd51, 24'd0, 24'd0);
    send_beat(1, 1, 24'h7fffff, 24'h7fffff, 24'h7fffff);
    send_beat(1, 1, 24'h800000, 24'h800000, 24'h800000);
    send_beat(1, 1, 24'h7fffff, 24'h800000, 24'h000001);
    send_beat(0, 1, 24'hffffff, 24'hffffff, 24'hffffff);
    send_beat(1, 1, 24'd101, 24'd6, 24'd8);
    write_size(16'd0);
    send_beat(1, 1, 24'd3, 24'd3, 24'd3);
    send_beat(1, 1, -24'sd3, 24'd3, 24'd3);
    write_size(16'hffff);
    send_beat(1, 1, 24'h7fffff, 24'h800000, 24'd1);
    send_beat(1, 1, -24'sd65535, 24'd65535, -24'sd65536);
    write_size(16'd1);
    send_beat(1, 1, 24'd1, 24'd1, 24'd1);
    idle_pct = 0;
    random_beats(150);
    idle_pct = 19;
    fork
      begin
        hold_off = 1;
        repeat (400) @(negedge clk);
        hold_off = 0;
      end
      random_beats(100);
    join
    write_size(16'd50);
    random_beats(250);
    write_size(16'd7);
    random_beats(200);
    write_size(16'd1000);
    random_beats(200);
    drain();
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule
`default_nettype wire

[voxel_hash_point_dedup_core.f]
hw/rtl/vhpd_pkg.sv
hw/rtl/vhpd_front.sv
hw/rtl/vhpd_fifo.sv
hw/rtl/vhpd_back.sv
hw/rtl/voxel_hash_point_dedup_core.sv
hw/rtl/vhpd_checker.sv
tb/sv/voxel_hash_point_dedup_core_tb.sv
